// File: hdl/sasr_pkg.sv
// Shared types and constants for the servo angle slew ramp.
`timescale 1ns / 1ps

package sasr_pkg;

    // Largest angle a command may set, in degrees.
    localparam logic [7:0] ANGLE_MAX = 8'd180;

    // Reset values of the configuration registers and of the slew step.
    localparam logic [14:0] MIN_PULSE_RESET = 15'd500;
    localparam logic [14:0] MAX_PULSE_RESET = 15'd2500;
    localparam logic [7:0]  LIMP_FRAMES_RESET = 8'd8;
    localparam logic [4:0]  STEP_RESET = 5'd1;

    // Configuration register indexes.
    localparam logic [1:0] CFG_MIN_PULSE = 2'd0;
    localparam logic [1:0] CFG_MAX_PULSE = 2'd1;
    localparam logic [1:0] CFG_LIMP_FRAMES = 2'd2;

    // Request kinds carried on the input tuser.
    localparam logic REQ_COMMAND = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    // Division by 180 is done as a shift by two and a reciprocal multiply by 1/45.
    // The reciprocal is exact for every dividend below 2^21.
    localparam logic [21:0] DIV_MUL = 22'd2982617;
    localparam int DIV_SHIFT = 27;

    // What a word does to the compare register.
    typedef enum logic [1:0] {
        OP_KEEP,
        OP_LOAD,
        OP_ZERO
    } cmp_op_t;

    // Word leaving the slew stage.
    typedef struct packed {
        cmp_op_t    op;
        logic [7:0] angle;
        logic       awake;
        logic       moving;
    } slew_word_t;

    // Word after the angle by span product.
    typedef struct packed {
        cmp_op_t            op;
        logic signed [24:0] prod;
        logic               awake;
        logic               moving;
    } prod_word_t;

    // Word after division by 180.
    typedef struct packed {
        cmp_op_t            op;
        logic signed [16:0] quot;
        logic               awake;
        logic               moving;
    } scaled_word_t;

endpackage

// File: hdl/sasr_slew.sv
// Slew state update: target commands, angle stepping and the limp countdown.
`timescale 1ns / 1ps

module sasr_slew (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  in_kind,
    input  logic signed [8:0]     in_target,
    input  logic [4:0]            in_step,
    input  logic [7:0]            limp_frames,
    output logic                  out_valid,
    input  logic                  out_ready,
    output sasr_pkg::slew_word_t  out_word
);

    logic [7:0] cur_angle_reg, cur_angle_next;
    logic [7:0] goal_angle_reg, goal_angle_next;
    logic [4:0] step_amount_reg, step_amount_next;
    logic [7:0] limp_count_reg, limp_count_next;
    logic       limp_pending_reg, limp_pending_next;
    logic       awake_reg, awake_next;
    logic       valid_reg;
    sasr_pkg::slew_word_t word_reg, word_next;
    logic       accept;
    logic [7:0] clamped;
    logic [4:0] step_fixed;
    logic [8:0] up_sum;
    logic [8:0] down_limit;

    assign in_ready = !valid_reg || out_ready;
    assign accept = in_valid && in_ready;
    assign out_valid = valid_reg;
    assign out_word = word_reg;

    always_comb begin
        if (in_target[8]) begin
            clamped = 8'd0;
        end else if (in_target[7:0] > sasr_pkg::ANGLE_MAX) begin
            clamped = sasr_pkg::ANGLE_MAX;
        end else begin
            clamped = in_target[7:0];
        end
        step_fixed = (in_step == 5'd0) ? 5'd1 : in_step;
        up_sum = {1'b0, cur_angle_reg} + {4'b0, step_amount_reg};
        down_limit = {1'b0, goal_angle_reg} + {4'b0, step_amount_reg};

        cur_angle_next = cur_angle_reg;
        goal_angle_next = goal_angle_reg;
        step_amount_next = step_amount_reg;
        limp_count_next = limp_count_reg;
        limp_pending_next = limp_pending_reg;
        awake_next = awake_reg;
        word_next.op = sasr_pkg::OP_KEEP;

        if (in_kind == sasr_pkg::REQ_COMMAND) begin
            if (cur_angle_reg == 8'd0 && clamped != 8'd0) begin
                awake_next = 1'b1;
            end
            goal_angle_next = clamped;
            step_amount_next = step_fixed;
            if (clamped == 8'd0) begin
                limp_pending_next = 1'b1;
                limp_count_next = limp_frames;
            end else begin
                limp_pending_next = 1'b0;
            end
        end else if (cur_angle_reg != goal_angle_reg) begin
            word_next.op = sasr_pkg::OP_LOAD;
            if (goal_angle_reg > cur_angle_reg) begin
                cur_angle_next = (up_sum > {1'b0, goal_angle_reg}) ? goal_angle_reg
                                                                    : up_sum[7:0];
            end else begin
                cur_angle_next = ({1'b0, cur_angle_reg} >= down_limit)
                               ? cur_angle_reg - {3'b0, step_amount_reg}
                               : goal_angle_reg;
            end
        end else if (limp_pending_reg) begin
            if (limp_count_reg != 8'd0) begin
                limp_count_next = limp_count_reg - 8'd1;
            end else begin
                word_next.op = sasr_pkg::OP_ZERO;
                awake_next = 1'b0;
                limp_pending_next = 1'b0;
            end
        end

        word_next.angle = cur_angle_next;
        word_next.awake = awake_next;
        word_next.moving = (cur_angle_next != goal_angle_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_angle_reg <= 8'd0;
            goal_angle_reg <= 8'd0;
            step_amount_reg <= sasr_pkg::STEP_RESET;
            limp_count_reg <= 8'd0;
            limp_pending_reg <= 1'b0;
            awake_reg <= 1'b0;
            valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                cur_angle_reg <= cur_angle_next;
                goal_angle_reg <= goal_angle_next;
                step_amount_reg <= step_amount_next;
                limp_count_reg <= limp_count_next;
                limp_pending_reg <= limp_pending_next;
                awake_reg <= awake_next;
            end
            if (in_ready) begin
                valid_reg <= in_valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            word_reg <= word_next;
        end
    end

endmodule

// File: hdl/sasr_scale.sv
// Two-stage pipeline that scales an angle by the pulse span and divides by 180.
`timescale 1ns / 1ps

module sasr_scale (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  sasr_pkg::slew_word_t    in_word,
    input  logic [14:0]             min_pulse,
    input  logic [14:0]             max_pulse,
    output logic                    out_valid,
    input  logic                    out_ready,
    output sasr_pkg::scaled_word_t  out_word
);

    logic                   prod_valid_reg;
    sasr_pkg::prod_word_t   prod_word_reg, prod_word_next;
    logic                   quot_valid_reg;
    sasr_pkg::scaled_word_t quot_word_reg, quot_word_next;
    logic                   ready_prod;
    logic                   ready_quot;
    logic signed [15:0]     span;
    logic signed [8:0]      angle_s;
    logic [24:0]            mag;
    logic [20:0]            div_in;
    logic [42:0]            div_prod;
    logic [15:0]            quot_mag;

    assign ready_quot = !quot_valid_reg || out_ready;
    assign ready_prod = !prod_valid_reg || ready_quot;
    assign in_ready = ready_prod;
    assign out_valid = quot_valid_reg;
    assign out_word = quot_word_reg;

    // Product of angle and signed pulse span.
    always_comb begin
        span = $signed({1'b0, max_pulse}) - $signed({1'b0, min_pulse});
        angle_s = $signed({1'b0, in_word.angle});
        prod_word_next.op = in_word.op;
        prod_word_next.prod = angle_s * span;
        prod_word_next.awake = in_word.awake;
        prod_word_next.moving = in_word.moving;
    end

    // Quotient truncated toward zero, taken on the magnitude.
    always_comb begin
        mag = prod_word_reg.prod[24] ? 25'(-prod_word_reg.prod) : 25'(prod_word_reg.prod);
        div_in = mag[22:2];
        div_prod = 43'(div_in) * 43'(sasr_pkg::DIV_MUL);
        quot_mag = div_prod[sasr_pkg::DIV_SHIFT +: 16];
        quot_word_next.op = prod_word_reg.op;
        quot_word_next.quot = prod_word_reg.prod[24] ? -$signed({1'b0, quot_mag})
                                                     : $signed({1'b0, quot_mag});
        quot_word_next.awake = prod_word_reg.awake;
        quot_word_next.moving = prod_word_reg.moving;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_valid_reg <= 1'b0;
            quot_valid_reg <= 1'b0;
        end else begin
            if (ready_prod) begin
                prod_valid_reg <= in_valid;
            end
            if (ready_quot) begin
                quot_valid_reg <= prod_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ready_prod && in_valid) begin
            prod_word_reg <= prod_word_next;
        end
        if (ready_quot && prod_valid_reg) begin
            quot_word_reg <= quot_word_next;
        end
    end

endmodule

// File: hdl/servo_angle_slew_ramp_core.sv
// Top level of the servo angle slew ramp with configuration and output registers.
`timescale 1ns / 1ps

// Every input word yields one result word, and a new word is taken in every cycle
// while the output is drained. A word is a target command or a frame tick, selected
// by s_tuser. The angle and limp state update is registered at the accepting edge
// and is the only loop from one word to the next. A product stage, a divide-by-180
// stage and the output register that holds the compare value then follow it in that
// order. Configuration writes are taken in any cycle and are meant to happen while
// no word is in flight.

module servo_angle_slew_ramp_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [14:0] cfg_wr_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,  // commanded_angle[8:0], step_degrees[13:9], zero pad
    input  logic        s_tuser,  // req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata   // pulse_compare[14:0], hold_awake[15], moving[16], pad
);

    logic [14:0] min_pulse_reg;
    logic [14:0] max_pulse_reg;
    logic [7:0]  limp_frames_reg;

    logic                   slew_valid;
    logic                   slew_ready;
    sasr_pkg::slew_word_t   slew_word;
    logic                   sc_valid;
    logic                   sc_ready;
    sasr_pkg::scaled_word_t sc_word;

    logic        m_tvalid_reg;
    logic [14:0] compare_reg, compare_next;
    logic        awake_out_reg;
    logic        moving_out_reg;
    logic signed [17:0] pulse_sum;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_pulse_reg <= sasr_pkg::MIN_PULSE_RESET;
            max_pulse_reg <= sasr_pkg::MAX_PULSE_RESET;
            limp_frames_reg <= sasr_pkg::LIMP_FRAMES_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                sasr_pkg::CFG_MIN_PULSE: begin
                    min_pulse_reg <= cfg_wr_data;
                end
                sasr_pkg::CFG_MAX_PULSE: begin
                    max_pulse_reg <= cfg_wr_data;
                end
                sasr_pkg::CFG_LIMP_FRAMES: begin
                    limp_frames_reg <= cfg_wr_data[7:0];
                end
                default: begin
                end
            endcase
        end
    end

    sasr_slew u_slew (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_kind     (s_tuser),
        .in_target   ($signed(s_tdata[8:0])),
        .in_step     (s_tdata[13:9]),
        .limp_frames (limp_frames_reg),
        .out_valid   (slew_valid),
        .out_ready   (slew_ready),
        .out_word    (slew_word)
    );

    sasr_scale u_scale (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (slew_valid),
        .in_ready  (slew_ready),
        .in_word   (slew_word),
        .min_pulse (min_pulse_reg),
        .max_pulse (max_pulse_reg),
        .out_valid (sc_valid),
        .out_ready (sc_ready),
        .out_word  (sc_word)
    );

    assign sc_ready = !m_tvalid_reg || m_tready;

    always_comb begin
        pulse_sum = $signed({3'b0, min_pulse_reg}) + 18'(sc_word.quot);
        unique case (sc_word.op)
            sasr_pkg::OP_KEEP: begin
                compare_next = compare_reg;
            end
            sasr_pkg::OP_LOAD: begin
                if (pulse_sum[17]) begin
                    compare_next = 15'd0;
                end else if (pulse_sum[16:15] != 2'b00) begin
                    compare_next = 15'h7FFF;
                end else begin
                    compare_next = pulse_sum[14:0];
                end
            end
            sasr_pkg::OP_ZERO: begin
                compare_next = 15'd0;
            end
            default: begin
                compare_next = compare_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
            compare_reg <= 15'd0;
        end else if (sc_ready) begin
            m_tvalid_reg <= sc_valid;
            if (sc_valid) begin
                compare_reg <= compare_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (sc_ready && sc_valid) begin
            awake_out_reg <= sc_word.awake;
            moving_out_reg <= sc_word.moving;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata = {7'b0, moving_out_reg, awake_out_reg, compare_reg};

endmodule

// File: tb/sv/servo_angle_slew_ramp_core_tb.sv
// Self-checking stream testbench for the servo angle slew ramp core.
`timescale 1ns / 1ps

module servo_angle_slew_ramp_core_tb;

    localparam int IDLE_LIMIT = 2000;

    typedef struct {
        logic       req;
        logic [8:0] target;
        logic [4:0] step_deg;
    } servo_word_t;

    typedef struct {
        logic [14:0] pulse;
        logic        awake;
        logic        moving;
    } servo_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_index = sasr_pkg::CFG_MIN_PULSE;
    logic [14:0] cfg_wr_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;  // commanded_angle[8:0], step_degrees[13:9], zero pad
    logic        s_tuser = sasr_pkg::REQ_COMMAND;  // req_type
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;  // pulse_compare[14:0], hold_awake[15], moving[16], pad

    servo_angle_slew_ramp_core u_top (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    servo_word_t   servo_word_q[$];
    servo_result_t pending_result_q[$];
    servo_result_t expected_word;

    // Predicted state of the block and its registers.
    logic [14:0] min_cfg = sasr_pkg::MIN_PULSE_RESET;
    logic [14:0] max_cfg = sasr_pkg::MAX_PULSE_RESET;
    logic [7:0]  limp_frames_cfg = sasr_pkg::LIMP_FRAMES_RESET;
    logic [7:0]  cur_angle = '0;
    logic [7:0]  goal_angle = '0;
    logic [4:0]  step_amt = sasr_pkg::STEP_RESET;
    logic [7:0]  limp_left = '0;
    logic        limp_armed = 1'b0;
    logic        awake = 1'b0;
    logic [14:0] compare_val = '0;

    // Angle the stimulus generator expects the block to have reached.
    logic [7:0] gen_angle = '0;
    logic [7:0] gen_goal = '0;
    logic [4:0] gen_step = sasr_pkg::STEP_RESET;

    int send_idle_pct = 0;
    int stall_pct = 0;
    int hold_left = 0;
    int held_cycles = 0;
    int words_queued = 0;
    int words_accepted = 0;
    int results_checked = 0;
    int limp_releases = 0;
    int settings_used = 1;
    int errors = 0;
    int idle_cycles = 0;
    logic word_taken = 1'b0;

    function automatic logic [7:0] clamp_angle(input logic [8:0] raw);
        int t;
        t = $signed(raw);
        if (t < 0) t = 0;
        if (t > int'(sasr_pkg::ANGLE_MAX)) t = int'(sasr_pkg::ANGLE_MAX);
        return 8'(t);
    endfunction

    function automatic logic [4:0] slew_step(input logic [4:0] raw);
        return (raw == 5'd0) ? 5'd1 : raw;
    endfunction

    function automatic logic [7:0] next_angle(input logic [7:0] cur, input logic [7:0] goal,
                                              input logic [4:0] st);
        int c;
        int g;
        int s;
        c = cur;
        g = goal;
        s = st;
        if (g > c) begin
            c = c + s;
            if (c > g) c = g;
        end else if (c >= g + s) begin
            c = c - s;
        end else begin
            c = g;
        end
        return 8'(c);
    endfunction

    function automatic logic [14:0] pulse_for(input logic [7:0] angle);
        int lo;
        int span;
        int v;
        lo = int'(min_cfg);
        span = int'(max_cfg) - lo;
        v = lo + (int'(angle) * span) / 180;
        if (v < 0) v = 0;
        if (v > 32767) v = 32767;
        return 15'(v);
    endfunction

    function automatic void advance_servo(input servo_word_t w);
        servo_result_t r;
        if (w.req == sasr_pkg::REQ_COMMAND) begin
            if (cur_angle == 8'd0 && clamp_angle(w.target) != 8'd0) awake = 1'b1;
            goal_angle = clamp_angle(w.target);
            step_amt = slew_step(w.step_deg);
            if (goal_angle == 8'd0) begin
                limp_armed = 1'b1;
                limp_left = limp_frames_cfg;
            end else begin
                limp_armed = 1'b0;
            end
        end else if (cur_angle != goal_angle) begin
            cur_angle = next_angle(cur_angle, goal_angle, step_amt);
            compare_val = pulse_for(cur_angle);
        end else if (limp_armed) begin
            if (limp_left != 8'd0) begin
                limp_left = limp_left - 8'd1;
            end else begin
                compare_val = '0;
                awake = 1'b0;
                limp_armed = 1'b0;
                limp_releases++;
            end
        end
        r.pulse = compare_val;
        r.awake = awake;
        r.moving = (cur_angle != goal_angle);
        pending_result_q.push_back(r);
    endfunction

    task automatic queue_command(input int tgt, input int stp);
        servo_word_t w;
        w.req = sasr_pkg::REQ_COMMAND;
        w.target = tgt[8:0];
        w.step_deg = stp[4:0];
        servo_word_q.push_back(w);
        words_queued++;
        gen_goal = clamp_angle(w.target);
        gen_step = slew_step(w.step_deg);
    endtask

    task automatic queue_ticks(input int n);
        servo_word_t w;
        w.req = sasr_pkg::REQ_TICK;
        repeat (n) begin
            w.target = 9'($urandom_range(511));
            w.step_deg = 5'($urandom_range(31));
            servo_word_q.push_back(w);
            words_queued++;
            if (gen_angle != gen_goal) gen_angle = next_angle(gen_angle, gen_goal, gen_step);
        end
    endtask

    task automatic queue_random(input int n);
        int first;
        int sel;
        int tgt;
        int stp;
        int gap;
        int need;
        first = words_queued;
        while (words_queued - first < n) begin
            sel = $urandom_range(99);
            if (sel < 25) tgt = 0;
            else if (sel < 35) tgt = $urandom_range(511);
            else tgt = $urandom_range(180, 1);
            stp = ($urandom_range(7) == 0) ? $urandom_range(31) : $urandom_range(20, 1);
            queue_command(tgt, stp);
            gap = (gen_goal > gen_angle) ? gen_goal - gen_angle : gen_angle - gen_goal;
            need = (gap + gen_step - 1) / gen_step;
            if ($urandom_range(4) == 0) begin
                queue_ticks($urandom_range(need));
            end else if (gen_goal == 8'd0) begin
                if ($urandom_range(1) == 0) queue_ticks(need + limp_frames_cfg + 1 +
                                                        $urandom_range(2));
                else queue_ticks(need + $urandom_range(limp_frames_cfg + 2));
            end else begin
                queue_ticks(need + $urandom_range(3));
            end
        end
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [14:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wr_data <= val;
        case (idx)
            sasr_pkg::CFG_MIN_PULSE: min_cfg = val;
            sasr_pkg::CFG_MAX_PULSE: max_cfg = val;
            sasr_pkg::CFG_LIMP_FRAMES: limp_frames_cfg = val[7:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_limits(input int lo, input int hi, input int limp);
        write_reg(sasr_pkg::CFG_MIN_PULSE, 15'(lo));
        write_reg(sasr_pkg::CFG_MAX_PULSE, 15'(hi));
        write_reg(sasr_pkg::CFG_LIMP_FRAMES, 15'(limp));
        settings_used++;
    endtask

    task automatic wait_idle();
        while (servo_word_q.size() != 0 || pending_result_q.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    // Input side: acceptance at the rising edge, new word at the falling edge.
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) begin
            advance_servo(servo_word_q.pop_front());
            word_taken = 1'b1;
            words_accepted++;
        end
    end

    always @(negedge aclk) begin
        if (!s_tvalid || word_taken) begin
            word_taken = 1'b0;
            if (servo_word_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                s_tvalid <= 1'b1;
                s_tuser <= servo_word_q[0].req;
                s_tdata <= {2'b00, servo_word_q[0].step_deg, servo_word_q[0].target};
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge aclk) begin
        if (hold_left > 0) begin
            hold_left--;
            held_cycles++;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (m_tvalid && m_tready) begin
            if (pending_result_q.size() == 0) begin
                $display("%0t: unexpected word, expected none, actual %h", $time, m_tdata);
                errors++;
            end else begin
                expected_word = pending_result_q.pop_front();
                results_checked++;
                if (m_tdata[14:0] !== expected_word.pulse) begin
                    $display("%0t: pulse_compare expected %0d actual %0d", $time,
                             expected_word.pulse, m_tdata[14:0]);
                    errors++;
                end
                if (m_tdata[15] !== expected_word.awake) begin
                    $display("%0t: hold_awake expected %0d actual %0d", $time,
                             expected_word.awake, m_tdata[15]);
                    errors++;
                end
                if (m_tdata[16] !== expected_word.moving) begin
                    $display("%0t: moving expected %0d actual %0d", $time,
                             expected_word.moving, m_tdata[16]);
                    errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no word moved for %0d cycles", $time, IDLE_LIMIT);
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // A zero target while resting at zero still arms limp and then releases it.
        queue_command(0, 0);
        queue_ticks(9);
        // Out-of-range targets clamp to the ends of the travel.
        queue_command(255, 31);
        queue_ticks(6);
        queue_command(-256, 31);
        queue_ticks(7);
        queue_random(250);
        wait_idle();

        set_limits(0, 20000, 0);
        send_idle_pct = 48;
        queue_random(300);
        wait_idle();

        set_limits(20000, 0, 255);
        send_idle_pct = 0;
        stall_pct = 48;
        queue_random(350);
        wait_idle();

        set_limits(1000, 2000, 3);
        send_idle_pct = 17;
        stall_pct = 17;
        queue_random(300);
        wait_idle();

        // The receiver holds off long enough for the block to back up its input.
        set_limits(20000, 20000, 1);
        send_idle_pct = 0;
        stall_pct = 0;
        queue_random(300);
        repeat (20) @(posedge aclk);
        hold_left = 400;
        wait_idle();

        set_limits(500, 2500, 8);
        send_idle_pct = 17;
        stall_pct = 17;
        queue_random(350);
        wait_idle();

        $display("Checked %0d results from %0d command and tick words over %0d limit settings.",
                 results_checked, words_accepted, settings_used);
        $display("Saw %0d limp releases; the output was held off for %0d cycles.",
                 limp_releases, held_cycles);
        if (errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// File: sim.f
hdl/sasr_pkg.sv
hdl/sasr_slew.sv
hdl/sasr_scale.sv
hdl/servo_angle_slew_ramp_core.sv
tb/sv/servo_angle_slew_ramp_core_tb.sv
